// ===== design/npc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest palette color block.
// Depends on nothing; imported by npc_cell and nearest_palette_color.
package npc_pkg;

   localparam int unsigned CHANNEL_WIDTH = 8;
   localparam int unsigned INDEX_WIDTH   = 8;
   localparam int unsigned SQUARE_WIDTH  = 2 * CHANNEL_WIDTH;
   localparam int unsigned DIST_WIDTH    = 18;

   // 3 * 256 * 256: larger than any real distance, reported when nothing qualifies
   localparam logic [DIST_WIDTH-1:0] NO_MATCH_DISTANCE = 18'd196608;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   // One transaction as it travels down the chain of cells.
   typedef struct packed {
      logic                     valid;
      command_type              command;
      logic [INDEX_WIDTH-1:0]   entry_index;
      logic [CHANNEL_WIDTH-1:0] red;
      logic [CHANNEL_WIDTH-1:0] green;
      logic [CHANNEL_WIDTH-1:0] blue;
      logic                     excluded;
      logic [INDEX_WIDTH-1:0]   best_index;
      logic [DIST_WIDTH-1:0]    best_distance;
   } token_type;

endpackage

// ===== design/nearest_palette_color.sv =====
`timescale 1ns / 1ps
// Nearest palette color: chain of PALETTE_DEPTH-1 cells, one per searched entry.
// A request passes through one register per cell and then the output register before
// its response. Throughput: one transaction per cycle; a stalled response stalls the chain.
// Reset (synchronous): every entry excluded, chain and output register emptied.
// Uses npc_pkg and npc_cell.
module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256,
   parameter int unsigned DROPPED_BITS  = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [INDEX_WIDTH-1:0]   req_entry_index,
   input  logic [CHANNEL_WIDTH-1:0] req_red,
   input  logic [CHANNEL_WIDTH-1:0] req_green,
   input  logic [CHANNEL_WIDTH-1:0] req_blue,
   input  logic                     req_excluded,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [INDEX_WIDTH-1:0]   rsp_best_index,
   output logic [DIST_WIDTH-1:0]    rsp_best_distance
);

   // the last entry is never searched, so it gets no cell
   localparam int unsigned NUM_CELLS = PALETTE_DEPTH - 1;
   localparam logic [CHANNEL_WIDTH-1:0] KEEP_MASK =
      CHANNEL_WIDTH'({CHANNEL_WIDTH{1'b1}} << DROPPED_BITS);

   token_type chain_tok [NUM_CELLS+1];
   token_type head_tok;
   logic      advance;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [INDEX_WIDTH-1:0] rsp_best_index_ff;
   logic [DIST_WIDTH-1:0]  rsp_best_distance_ff;

   // hold the whole chain while a response waits
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      head_tok.valid         = req_valid;
      head_tok.command       = command_type'(req_command);
      head_tok.entry_index   = req_entry_index;
      head_tok.excluded      = req_excluded;
      head_tok.best_index    = '0;
      head_tok.best_distance = NO_MATCH_DISTANCE;
      if (command_type'(req_command) == CMD_QUERY) begin
         head_tok.red   = req_red & KEEP_MASK;
         head_tok.green = req_green & KEEP_MASK;
         head_tok.blue  = req_blue & KEEP_MASK;
      end else begin
         head_tok.red   = req_red;
         head_tok.green = req_green;
         head_tok.blue  = req_blue;
      end
   end

   assign chain_tok[0] = head_tok;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      npc_cell #(
         .CELL_INDEX(k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .upstream_tok  (chain_tok[k]),
         .downstream_tok(chain_tok[k+1])
      );
   end

   assign rsp_valid_in = chain_tok[NUM_CELLS].valid
                         && (chain_tok[NUM_CELLS].command == CMD_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_best_index_ff    <= chain_tok[NUM_CELLS].best_index;
         rsp_best_distance_ff <= chain_tok[NUM_CELLS].best_distance;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_best_index_ff;
   assign rsp_best_distance = rsp_best_distance_ff;

endmodule

// ===== design/npc_cell.sv =====
`timescale 1ns / 1ps
// One palette cell: holds one entry, applies loads addressed to it and
// updates the running best match of queries passing through. Uses npc_pkg.
module npc_cell
   import npc_pkg::*;
#(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type upstream_tok,
   output token_type downstream_tok
);

   localparam logic [INDEX_WIDTH-1:0] MY_INDEX = INDEX_WIDTH'(CELL_INDEX);

   logic [CHANNEL_WIDTH-1:0] red_ff;
   logic [CHANNEL_WIDTH-1:0] green_ff;
   logic [CHANNEL_WIDTH-1:0] blue_ff;
   logic                     excluded_ff;
   token_type                tok_ff;
   token_type                tok_in;

   logic [CHANNEL_WIDTH-1:0] diff_red;
   logic [CHANNEL_WIDTH-1:0] diff_green;
   logic [CHANNEL_WIDTH-1:0] diff_blue;
   logic [SQUARE_WIDTH-1:0]  sq_red;
   logic [SQUARE_WIDTH-1:0]  sq_green;
   logic [SQUARE_WIDTH-1:0]  sq_blue;
   logic [DIST_WIDTH-1:0]    sum_sq;
   logic                     load_hit;
   logic                     query_hit;

   always_comb begin
      diff_red   = (upstream_tok.red >= red_ff) ? upstream_tok.red - red_ff
                                                : red_ff - upstream_tok.red;
      diff_green = (upstream_tok.green >= green_ff) ? upstream_tok.green - green_ff
                                                    : green_ff - upstream_tok.green;
      diff_blue  = (upstream_tok.blue >= blue_ff) ? upstream_tok.blue - blue_ff
                                                  : blue_ff - upstream_tok.blue;
      sq_red   = SQUARE_WIDTH'(diff_red) * SQUARE_WIDTH'(diff_red);
      sq_green = SQUARE_WIDTH'(diff_green) * SQUARE_WIDTH'(diff_green);
      sq_blue  = SQUARE_WIDTH'(diff_blue) * SQUARE_WIDTH'(diff_blue);
      sum_sq   = DIST_WIDTH'(sq_red) + DIST_WIDTH'(sq_green) + DIST_WIDTH'(sq_blue);

      load_hit  = upstream_tok.valid && (upstream_tok.command == CMD_LOAD)
                  && (upstream_tok.entry_index == MY_INDEX);
      // strict compare keeps the lowest index on a tie
      query_hit = upstream_tok.valid && (upstream_tok.command == CMD_QUERY)
                  && !excluded_ff && (sum_sq < upstream_tok.best_distance);

      tok_in = upstream_tok;
      if (query_hit) begin
         tok_in.best_index    = MY_INDEX;
         tok_in.best_distance = sum_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excluded_ff <= 1'b1;
      end else if (advance && load_hit) begin
         excluded_ff <= upstream_tok.excluded;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         red_ff   <= upstream_tok.red;
         green_ff <= upstream_tok.green;
         blue_ff  <= upstream_tok.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign downstream_tok = tok_ff;

endmodule

// ===== sim/nearest_palette_color_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for nearest_palette_color: mirrors the palette from accepted loads,
// predicts the nearest entry of every accepted query and compares responses in order.
// Depends on npc_pkg for widths, the command encoding and the no-match distance.
module nearest_palette_color_checker
   import npc_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256,
   parameter int unsigned DROPPED_BITS  = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_command,
   input  logic [INDEX_WIDTH-1:0]   req_entry_index,
   input  logic [CHANNEL_WIDTH-1:0] req_red,
   input  logic [CHANNEL_WIDTH-1:0] req_green,
   input  logic [CHANNEL_WIDTH-1:0] req_blue,
   input  logic                     req_excluded,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [INDEX_WIDTH-1:0]   rsp_best_index,
   input  logic [DIST_WIDTH-1:0]    rsp_best_distance,
   output int unsigned              error_count,
   output int unsigned              outstanding
);

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] red;
      logic [CHANNEL_WIDTH-1:0] green;
      logic [CHANNEL_WIDTH-1:0] blue;
      logic                     excluded;
   } swatch_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] index;
      logic [DIST_WIDTH-1:0]  distance;
   } match_type;

   swatch_type palette_copy [PALETTE_DEPTH];
   match_type  expected_matches [$];

   function automatic match_type nearest_entry(logic [CHANNEL_WIDTH-1:0] red,
                                               logic [CHANNEL_WIDTH-1:0] green,
                                               logic [CHANNEL_WIDTH-1:0] blue);
      logic [CHANNEL_WIDTH-1:0] keep;
      int dr, dg, db;
      int unsigned sum_sq;
      int unsigned i;
      match_type best;
      keep = {CHANNEL_WIDTH{1'b1}} << DROPPED_BITS;
      best.index = '0;
      best.distance = NO_MATCH_DISTANCE;
      // the last entry is loadable but never searched
      for (i = 0; i + 1 < PALETTE_DEPTH; i++) begin
         if (!palette_copy[i].excluded) begin
            dr = int'(red & keep) - int'(palette_copy[i].red);
            dg = int'(green & keep) - int'(palette_copy[i].green);
            db = int'(blue & keep) - int'(palette_copy[i].blue);
            sum_sq = dr * dr + dg * dg + db * db;
            // strict compare: ties keep the lower index
            if (sum_sq < best.distance) begin
               best.distance = DIST_WIDTH'(sum_sq);
               best.index = INDEX_WIDTH'(i);
            end
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin : track
      int unsigned i;
      match_type want;
      if (reset) begin
         for (i = 0; i < PALETTE_DEPTH; i++) begin
            palette_copy[i] = '{red: '0, green: '0, blue: '0, excluded: 1'b1};
         end
         expected_matches.delete();
         error_count = 0;
      end else begin
         // compare before predicting: a query never answers in its own cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               error_count++;
               $display("%t: unexpected response: expected none, actual index %0d distance %0d",
                        $time, rsp_best_index, rsp_best_distance);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_best_index !== want.index) begin
                  error_count++;
                  $display("%t: best_index mismatch: expected %0d, actual %0d",
                           $time, want.index, rsp_best_index);
               end
               if (rsp_best_distance !== want.distance) begin
                  error_count++;
                  $display("%t: best_distance mismatch: expected %0d, actual %0d",
                           $time, want.distance, rsp_best_distance);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (command_type'(req_command) == CMD_LOAD) begin
               if (req_entry_index < PALETTE_DEPTH) begin
                  palette_copy[req_entry_index] = '{red: req_red, green: req_green,
                                                    blue: req_blue, excluded: req_excluded};
               end
            end else begin
               expected_matches.push_back(nearest_entry(req_red, req_green, req_blue));
            end
         end
      end
      outstanding = expected_matches.size();
   end

endmodule

// ===== sim/nearest_palette_color_test.sv =====
`timescale 1ns / 1ps
// Top of the nearest_palette_color testbench: clock, reset, paced stimulus and verdict.
// Depends on npc_pkg, nearest_palette_color and nearest_palette_color_checker.
module nearest_palette_color_test
   import npc_pkg::*;
();

   localparam int unsigned RANDOM_ITEMS    = 1850;
   localparam int unsigned SWEEP_AT        = 900;
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned DRAIN_CYCLES    = 300;
   localparam int unsigned PRESSURE_AFTER  = 400;
   localparam int unsigned PRESSURE_CYCLES = 1200;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_command = 1'b0;
   logic [INDEX_WIDTH-1:0]   req_entry_index = '0;
   logic [CHANNEL_WIDTH-1:0] req_red = '0;
   logic [CHANNEL_WIDTH-1:0] req_green = '0;
   logic [CHANNEL_WIDTH-1:0] req_blue = '0;
   logic                     req_excluded = 1'b0;
   logic                     rsp_ready = 1'b0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic [INDEX_WIDTH-1:0]   rsp_best_index;
   logic [DIST_WIDTH-1:0]    rsp_best_distance;

   int unsigned error_count;
   int unsigned outstanding;
   int unsigned accepted_count = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;
   logic [CHANNEL_WIDTH-1:0] last_red = '0;
   logic [CHANNEL_WIDTH-1:0] last_green = '0;
   logic [CHANNEL_WIDTH-1:0] last_blue = '0;

   always #5 clock = ~clock;

   nearest_palette_color dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_excluded      (req_excluded),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

   nearest_palette_color_checker match_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_excluded      (req_excluded),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .error_count       (error_count),
      .outstanding       (outstanding)
   );

   // Close a burst with a random gap, or keep valid high for the next transaction.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 24);
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(command_type command, logic [INDEX_WIDTH-1:0] index,
                            logic [CHANNEL_WIDTH-1:0] red, logic [CHANNEL_WIDTH-1:0] green,
                            logic [CHANNEL_WIDTH-1:0] blue, logic excluded);
      req_valid <= 1'b1;
      req_command <= command;
      req_entry_index <= index;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      req_excluded <= excluded;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_count++;
      pace();
   endtask

   task automatic load(logic [INDEX_WIDTH-1:0] index, logic [CHANNEL_WIDTH-1:0] red,
                       logic [CHANNEL_WIDTH-1:0] green, logic [CHANNEL_WIDTH-1:0] blue,
                       logic excluded);
      last_red = red;
      last_green = green;
      last_blue = blue;
      send_item(CMD_LOAD, index, red, green, blue, excluded);
   endtask

   // entry_index and excluded carry noise on queries
   task automatic query(logic [CHANNEL_WIDTH-1:0] red, logic [CHANNEL_WIDTH-1:0] green,
                        logic [CHANNEL_WIDTH-1:0] blue);
      send_item(CMD_QUERY, 8'($urandom_range(0, 255)), red, green, blue,
                1'($urandom_range(0, 1)));
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : response_stall
      int unsigned mode;
      int unsigned span;
      bit held;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 4);
         span = $urandom_range(8, 96);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0, 1: rsp_ready <= 1'b1;
               2: rsp_ready <= ($urandom_range(0, 1) == 1);
               3: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         // hold off long enough for the chain to fill and stall the sender
         if (!held && accepted_count >= PRESSURE_AFTER) begin
            held = 1'b1;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned i;
      bit swept;
      logic [CHANNEL_WIDTH-1:0] red, green, blue;
      logic [INDEX_WIDTH-1:0] index;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty palette: nothing qualifies
      query(8'd0, 8'd0, 8'd0);
      query(8'd255, 8'd255, 8'd255);
      // last entry is never searched
      load(8'd255, 8'd10, 8'd20, 8'd30, 1'b0);
      query(8'd10, 8'd20, 8'd30);
      // far corner and low-bit truncation
      load(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      query(8'd255, 8'd255, 8'd255);
      query(8'd3, 8'd3, 8'd3);
      // tie between two equal entries: lower index wins
      load(8'd5, 8'd100, 8'd100, 8'd100, 1'b0);
      load(8'd10, 8'd100, 8'd100, 8'd100, 1'b0);
      query(8'd101, 8'd102, 8'd103);
      // excluded entry is skipped
      load(8'd5, 8'd100, 8'd100, 8'd100, 1'b1);
      query(8'd100, 8'd100, 8'd100);
      load(8'd254, 8'd255, 8'd255, 8'd255, 1'b0);
      query(8'd255, 8'd255, 8'd255);
      load(8'd1, 8'd255, 8'd0, 8'd255, 1'b0);
      query(8'd0, 8'd255, 8'd0);
      // exclude everything searched again
      load(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      load(8'd1, 8'd255, 8'd0, 8'd255, 1'b1);
      load(8'd10, 8'd100, 8'd100, 8'd100, 1'b1);
      load(8'd254, 8'd255, 8'd255, 8'd255, 1'b1);
      query(8'd128, 8'd128, 8'd128);
      query(8'd255, 8'd0, 8'd127);

      sent = 0;
      swept = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (!swept && sent >= SWEEP_AT) begin
            // drop every searched entry: reload each with random colors and excluded set
            swept = 1'b1;
            for (i = 0; i + 1 < 256; i++) begin
               load(8'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b1);
            end
            query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
            query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
            sent += 257;
         end else if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 7))
               0: index = 8'd0;
               1: index = 8'd254;
               2: index = 8'd255;
               default: index = 8'($urandom_range(0, 255));
            endcase
            // coarse colors make equal-distance ties likely
            if ($urandom_range(0, 1) == 1) begin
               red = 8'($urandom_range(0, 255));
               green = 8'($urandom_range(0, 255));
               blue = 8'($urandom_range(0, 255));
            end else begin
               red = 8'($urandom_range(0, 5) * 51);
               green = 8'($urandom_range(0, 5) * 51);
               blue = 8'($urandom_range(0, 5) * 51);
            end
            load(index, red, green, blue, $urandom_range(0, 5) == 0);
            sent++;
         end else begin
            if ($urandom_range(0, 9) < 3) begin
               red = last_red ^ 8'($urandom_range(0, 3));
               green = last_green ^ 8'($urandom_range(0, 3));
               blue = last_blue ^ 8'($urandom_range(0, 3));
            end else begin
               red = 8'($urandom_range(0, 255));
               green = 8'($urandom_range(0, 255));
               blue = 8'($urandom_range(0, 255));
            end
            query(red, green, blue);
            sent++;
         end
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
